// ===== design/fed_pkg.sv =====
`default_nettype none

package fed_pkg;

	// Default sizes of the delay line.
	localparam int DEPTH_DEF       = 262144;
	localparam int SAMPLE_BITS_DEF = 24;

	// Configuration register widths.
	localparam int CFG_BITS      = 18;
	localparam int MS_BITS       = 12;
	localparam int RATE_BITS     = 18;
	localparam int PERMILLE_BITS = 11;
	localparam int MAG_BITS      = 10;

	// Derived settings.
	localparam int DELAY_BITS    = 20;
	localparam int LVL_GAIN_BITS = 17;
	localparam int FB_GAIN_BITS  = 16;
	localparam int GAIN_FRAC     = 16;

	// Cycles from a register write until the derived settings are valid.
	localparam logic [1:0] SETTLE = 2'd3;

	localparam logic [MS_BITS-1:0]  MS_MAX    = 12'd4000;
	localparam logic [MAG_BITS-1:0] LVL_LIMIT = 10'd1000;
	localparam logic [MAG_BITS-1:0] FB_LIMIT  = 10'd999;

	// Register values after reset.
	localparam logic [MS_BITS-1:0]         DELAY_MS_RST = 12'd500;
	localparam logic [RATE_BITS-1:0]       RATE_RST     = 18'd48000;
	localparam logic signed [PERMILLE_BITS-1:0] LEVEL_RST    = 11'sd500;
	localparam logic signed [PERMILLE_BITS-1:0] FEEDBACK_RST = 11'sd300;

	// Division by 1000 as an exact reciprocal multiplication for values below 2^30.
	localparam int          DELAY_SHIFT = 40;
	localparam longint unsigned DELAY_DIV = 64'd1000;
	localparam logic [30:0] DELAY_RECIP =
		31'(((64'd1 << DELAY_SHIFT) + DELAY_DIV - 64'd1) / DELAY_DIV);

	// Gain = (a*a*2048 + 15625) / 31250, exact reciprocal for numerators below 2^31.
	localparam int          GAIN_SHIFT = 46;
	localparam longint unsigned GAIN_DIV = 64'd31250;
	localparam logic [30:0] GAIN_BIAS  = 31'd15625;
	localparam logic [31:0] GAIN_RECIP =
		32'(((64'd1 << GAIN_SHIFT) + GAIN_DIV - 64'd1) / GAIN_DIV);

	typedef enum logic [1:0] {
		REG_DELAY_MS,
		REG_SAMPLE_RATE,
		REG_LEVEL,
		REG_FEEDBACK
	} fed_reg_t;

	typedef struct packed {
		logic [MS_BITS-1:0]              delay_ms;
		logic [RATE_BITS-1:0]            sample_rate;
		logic signed [PERMILLE_BITS-1:0] level_permille;
		logic signed [PERMILLE_BITS-1:0] feedback_permille;
	} fed_cfg_t;

	typedef struct packed {
		logic [DELAY_BITS-1:0]    delay;
		logic [LVL_GAIN_BITS-1:0] lvl_gain;
		logic [FB_GAIN_BITS-1:0]  fb_gain;
	} fed_derived_t;

endpackage

`default_nettype wire

// ===== design/fed_ram.sv =====
`default_nettype none

module fed_ram #(
	parameter int DEPTH = fed_pkg::DEPTH_DEF,
	parameter int WIDTH = fed_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// The read data holds while no read is issued, so a stalled sample keeps its tap.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/fed_derive.sv =====
`default_nettype none

module fed_derive #(
	parameter int DEPTH = fed_pkg::DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire fed_pkg::fed_cfg_t cfg,
	output fed_pkg::fed_derived_t  der
);

	localparam logic [fed_pkg::DELAY_BITS-1:0] DMAX = fed_pkg::DELAY_BITS'(DEPTH - 2);

	function automatic logic [fed_pkg::MAG_BITS-1:0] clamp_mag(
		input logic signed [fed_pkg::PERMILLE_BITS-1:0] p,
		input logic [fed_pkg::MAG_BITS-1:0]             lim
	);
		logic [fed_pkg::PERMILLE_BITS-1:0] m;
		begin
			m = p[fed_pkg::PERMILLE_BITS-1] ? fed_pkg::PERMILLE_BITS'(-p)
				: fed_pkg::PERMILLE_BITS'(p);
			return (m > {1'b0, lim}) ? lim : m[fed_pkg::MAG_BITS-1:0];
		end
	endfunction

	logic [fed_pkg::MS_BITS-1:0]  ms_cl;
	logic [fed_pkg::MAG_BITS-1:0] lmag;
	logic [fed_pkg::MAG_BITS-1:0] fmag;
	logic [29:0]                  dprod;
	logic [19:0]                  lsq;
	logic [19:0]                  fsq;

	logic [29:0] dprod_s1;
	logic [19:0] lsq_s1;
	logic [19:0] fsq_s1;

	logic [30:0] lnum;
	logic [30:0] fnum;
	logic [fed_pkg::DELAY_BITS-1:0]    delay_s2;
	logic [fed_pkg::LVL_GAIN_BITS-1:0] lgain_s2;
	logic [fed_pkg::FB_GAIN_BITS-1:0]  fgain_s2;

	always_comb begin
		ms_cl = (cfg.delay_ms > fed_pkg::MS_MAX) ? fed_pkg::MS_MAX : cfg.delay_ms;
		lmag  = clamp_mag(cfg.level_permille, fed_pkg::LVL_LIMIT);
		fmag  = clamp_mag(cfg.feedback_permille, fed_pkg::FB_LIMIT);
		dprod = ms_cl * cfg.sample_rate;
		lsq   = lmag * lmag;
		fsq   = fmag * fmag;
	end

	always_ff @(posedge clk) begin
		dprod_s1 <= dprod;
		lsq_s1   <= lsq;
		fsq_s1   <= fsq;
	end

	assign lnum = {lsq_s1, 11'b0} + fed_pkg::GAIN_BIAS;
	assign fnum = {fsq_s1, 11'b0} + fed_pkg::GAIN_BIAS;

	always_ff @(posedge clk) begin
		delay_s2 <= fed_pkg::DELAY_BITS'((64'(dprod_s1) * 64'(fed_pkg::DELAY_RECIP))
			>> fed_pkg::DELAY_SHIFT);
		lgain_s2 <= fed_pkg::LVL_GAIN_BITS'((64'(lnum) * 64'(fed_pkg::GAIN_RECIP))
			>> fed_pkg::GAIN_SHIFT);
		fgain_s2 <= fed_pkg::FB_GAIN_BITS'((64'(fnum) * 64'(fed_pkg::GAIN_RECIP))
			>> fed_pkg::GAIN_SHIFT);
	end

	// A delay of zero samples becomes one; the line keeps two entries of slack.
	always_ff @(posedge clk) begin
		if (delay_s2 == '0) begin
			der.delay <= fed_pkg::DELAY_BITS'(1);
		end else if (delay_s2 > DMAX) begin
			der.delay <= DMAX;
		end else begin
			der.delay <= delay_s2;
		end
		der.lvl_gain <= lgain_s2;
		der.fb_gain  <= fgain_s2;
	end

endmodule

`default_nettype wire

// ===== design/fed_mix.sv =====
`default_nettype none

module fed_mix #(
	parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_BITS   = fed_pkg::LVL_GAIN_BITS
) (
	input  wire logic signed [SAMPLE_BITS-1:0] tap,
	input  wire logic        [GAIN_BITS-1:0]   gain,
	input  wire logic signed [SAMPLE_BITS-1:0] dry,
	output logic signed      [SAMPLE_BITS-1:0] sum
);

	localparam int SW    = SAMPLE_BITS;
	localparam int ROUND = 1 << (fed_pkg::GAIN_FRAC - 1);

	logic signed [SW+GAIN_BITS:0]   prod;
	logic signed [SW+GAIN_BITS+1:0] rnd;
	logic signed [SW+1:0]           total;
	logic                           ovf;

	assign prod  = tap * $signed({1'b0, gain});
	// Round half up onto the sample grid: add half an LSB, then an arithmetic shift.
	assign rnd   = (SW+GAIN_BITS+2)'(prod) + (SW+GAIN_BITS+2)'(ROUND);
	assign total = (SW+2)'(dry) + (SW+2)'(rnd >>> fed_pkg::GAIN_FRAC);
	assign ovf   = (total[SW+1:SW-1] != '0) && (total[SW+1:SW-1] != '1);

	always_comb begin
		if (!ovf) begin
			sum = total[SW-1:0];
		end else if (total[SW+1]) begin
			sum = {1'b1, {(SW-1){1'b0}}};
		end else begin
			sum = {1'b0, {(SW-1){1'b1}}};
		end
	end

endmodule

`default_nettype wire

// ===== design/feedback_echo_delay.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// --------  ---------  --------------------  ---------------------------------
// input     in         in_valid / in_ready   sample_in, block_end
// output    out        out_valid / out_ready sample_out, block_end_out
// config    in         cfg_we (no wait)      cfg_idx, cfg_data
//
// One sample is taken per clock cycle while the output and the settings do not hold
// it back; a sample passes through the tap stage into the output register. The rate
// is set by the delay-line loop: read the tap, scale it by the feedback gain, add the
// input, saturate and write back, with a forwarding register for a one-sample delay.
// The first sample of a block waits after reset or a register write, while the
// three-stage settings pipeline settles.
// Reset needs no clearing pass: entries not yet written since reset read as zero,
// tracked by the write pointer and a wrapped flag.
// A stalled output holds one result; a second sample then waits in the tap stage.

module feedback_echo_delay #(
	parameter int DEPTH       = fed_pkg::DEPTH_DEF,
	parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	input  wire logic                          block_end,

	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	output logic                               block_end_out,

	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_idx,
	input  wire logic [fed_pkg::CFG_BITS-1:0]  cfg_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int SW = SAMPLE_BITS;

	// Configuration registers and the settings derived from them.
	fed_pkg::fed_cfg_t     cfg_q;
	fed_pkg::fed_derived_t der;
	logic [1:0]            settle_q;

	// Settings latched at the first sample of each block.
	logic                               blk_start_q;
	logic [AW-1:0]                      delay_q;
	logic [fed_pkg::LVL_GAIN_BITS-1:0]  lvl_gain_q;
	logic [fed_pkg::FB_GAIN_BITS-1:0]   fb_gain_q;

	// Write position and fill tracking.
	logic [AW-1:0] wp_q;
	logic          wrapped_q;

	// Tap stage.
	logic                 valid_s1;
	logic signed [SW-1:0] x_s1;
	logic                 be_s1;
	logic [AW-1:0]        wa_s1;
	logic                 rd_ok_s1;
	logic                 fwd_s1;
	logic [SW-1:0]        fwd_data_q;

	// Output register.
	logic                 out_valid_q;
	logic signed [SW-1:0] sample_out_q;
	logic                 block_end_out_q;

	logic                 in_fire;
	logic                 s1_move;
	logic                 wr_en;
	logic [AW-1:0]        d_eff;
	logic                 wp_ge;
	logic [AW-1:0]        rd_addr;
	logic [SW-1:0]        rd_data;
	logic signed [SW-1:0] tap;
	logic signed [SW-1:0] echo;
	logic signed [SW-1:0] line_wr;

	// ------------------------------------------------------------------
	// Configuration port. Any write restarts the settle count.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_ms          <= fed_pkg::DELAY_MS_RST;
			cfg_q.sample_rate       <= fed_pkg::RATE_RST;
			cfg_q.level_permille    <= fed_pkg::LEVEL_RST;
			cfg_q.feedback_permille <= fed_pkg::FEEDBACK_RST;
			settle_q                <= fed_pkg::SETTLE;
		end else begin
			if (cfg_we) begin
				case (fed_pkg::fed_reg_t'(cfg_idx))
					fed_pkg::REG_DELAY_MS: begin
						cfg_q.delay_ms <= cfg_data[fed_pkg::MS_BITS-1:0];
					end
					fed_pkg::REG_SAMPLE_RATE: begin
						cfg_q.sample_rate <= cfg_data[fed_pkg::RATE_BITS-1:0];
					end
					fed_pkg::REG_LEVEL: begin
						cfg_q.level_permille <= $signed(cfg_data[fed_pkg::PERMILLE_BITS-1:0]);
					end
					fed_pkg::REG_FEEDBACK: begin
						cfg_q.feedback_permille <= $signed(cfg_data[fed_pkg::PERMILLE_BITS-1:0]);
					end
					default: begin
					end
				endcase
				settle_q <= fed_pkg::SETTLE;
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	fed_derive #(
		.DEPTH(DEPTH)
	) u_derive (
		.clk(clk),
		.cfg(cfg_q),
		.der(der)
	);

	// ------------------------------------------------------------------
	// Handshake. The tap stage moves on whenever the output register is free
	// or being emptied; the first sample of a block also needs settled settings.
	// ------------------------------------------------------------------
	assign s1_move  = !out_valid_q || out_ready;
	assign in_ready = (!valid_s1 || s1_move) && !(blk_start_q && (settle_q != '0));
	assign in_fire  = in_valid && in_ready;
	assign wr_en    = valid_s1 && s1_move;

	// The delay in force for the sample being taken: new settings apply at a block start.
	assign d_eff   = blk_start_q ? AW'(der.delay) : delay_q;
	assign wp_ge   = wp_q >= d_eff;
	assign rd_addr = wp_ge ? AW'(wp_q - d_eff)
		: AW'((AW+1)'(wp_q) + (AW+1)'(DEPTH) - (AW+1)'(d_eff));

	fed_ram #(
		.DEPTH(DEPTH),
		.WIDTH(SW)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wa_s1),
		.wr_data(line_wr),
		.rd_en(in_fire),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// ------------------------------------------------------------------
	// Control state.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_start_q <= 1'b1;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				blk_start_q <= block_end;
				if (wp_q == AW'(DEPTH - 1)) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AW'(1);
				end
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire && blk_start_q) begin
			delay_q    <= AW'(der.delay);
			lvl_gain_q <= der.lvl_gain;
			fb_gain_q  <= der.fb_gain;
		end
		if (in_fire) begin
			x_s1     <= sample_in;
			be_s1    <= block_end;
			wa_s1    <= wp_q;
			// Entries at or above the write pointer are unwritten until the first wrap.
			rd_ok_s1 <= wrapped_q || wp_ge;
			// The previous sample writes the entry being read in this same cycle.
			fwd_s1   <= wr_en && (wa_s1 == rd_addr);
		end
		if (wr_en) begin
			fwd_data_q <= line_wr;
		end
		if (s1_move && valid_s1) begin
			sample_out_q    <= echo;
			block_end_out_q <= be_s1;
		end
	end

	// ------------------------------------------------------------------
	// Tap stage arithmetic: echo output and the value fed back into the line.
	// ------------------------------------------------------------------
	always_comb begin
		if (fwd_s1) begin
			tap = $signed(fwd_data_q);
		end else if (rd_ok_s1) begin
			tap = $signed(rd_data);
		end else begin
			tap = '0;
		end
	end

	fed_mix #(
		.SAMPLE_BITS(SW),
		.GAIN_BITS(fed_pkg::LVL_GAIN_BITS)
	) u_mix_level (
		.tap(tap),
		.gain(lvl_gain_q),
		.dry(x_s1),
		.sum(echo)
	);

	fed_mix #(
		.SAMPLE_BITS(SW),
		.GAIN_BITS(fed_pkg::FB_GAIN_BITS)
	) u_mix_feedback (
		.tap(tap),
		.gain(fb_gain_q),
		.dry(x_s1),
		.sum(line_wr)
	);

	assign out_valid     = out_valid_q;
	assign sample_out    = sample_out_q;
	assign block_end_out = block_end_out_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// Settings are only latched once the derivation pipeline has caught up.
	a_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && blk_start_q) |-> (settle_q == '0))
		else $error("settings latched before the derivation pipeline settled");

	// The delay in force always lies between one sample and the line length less two.
	a_delay_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ((delay_q != '0) && (delay_q <= AW'(DEPTH - 2))))
		else $error("delay out of range");

	// A sample held in the tap stage keeps its line address and forwarding choice.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_move) |=> (valid_s1 && $stable(wa_s1) && $stable(fwd_s1)))
		else $error("tap stage changed while stalled");

endmodule

`default_nettype wire

// ===== dv/feedback_echo_delay_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the feedback echo. A predictor keeps its own copy of
// the delay line, the register values and the derived delay and gains. Every
// input transfer is run through it, and every output transfer is checked
// against the oldest expectation left in the queue.
module feedback_echo_delay_tb;

	localparam int DEPTH = fed_pkg::DEPTH_DEF;
	localparam int SB    = fed_pkg::SAMPLE_BITS_DEF;

	localparam longint SMP_MAX = (64'sd1 <<< (SB - 1)) - 1;
	localparam longint SMP_MIN = -SMP_MAX - 1;

	logic                         clk;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_ready;
	logic signed [SB-1:0]         sample_in = '0;
	logic                         block_end = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic signed [SB-1:0]         sample_out;
	logic                         block_end_out;
	logic                         cfg_we    = 1'b0;
	logic [1:0]                   cfg_idx   = '0;
	logic [fed_pkg::CFG_BITS-1:0] cfg_data  = '0;

	// Directed rows may carry a result that is typed in by hand. These travel
	// with the payload so the monitor sees them at the transfer edge.
	bit                   row_typed = 1'b0;
	logic signed [SB-1:0] row_want  = '0;

	// When set, neither side inserts idle cycles.
	bit steady = 1'b0;
	int n_errors = 0;

	feedback_echo_delay u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_in    (sample_in),
		.block_end    (block_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_out),
		.block_end_out(block_end_out),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor state. The line is a two-state array, so it starts at zero
	// just as the block's line does after reset.
	// ------------------------------------------------------------------
	int                                       echo_line [DEPTH];
	int                                       wr_ptr = 0;
	logic [fed_pkg::MS_BITS-1:0]              ms_reg    = fed_pkg::DELAY_MS_RST;
	logic [fed_pkg::RATE_BITS-1:0]            rate_reg  = fed_pkg::RATE_RST;
	logic signed [fed_pkg::PERMILLE_BITS-1:0] level_reg = fed_pkg::LEVEL_RST;
	logic signed [fed_pkg::PERMILLE_BITS-1:0] fb_reg    = fed_pkg::FEEDBACK_RST;
	int                                       tap_delay = 1;
	longint                                   level_gain_q = 0;
	longint                                   fb_gain_q = 0;
	// Set while the next sample opens a host block; settings are latched then.
	bit                                       take_settings = 1'b1;

	typedef struct {
		logic signed [SB-1:0] smp;
		logic                 be;
	} echo_result_t;

	echo_result_t pending_echo [$];

	function automatic longint clip(input longint v);
		if (v > SMP_MAX)
			return SMP_MAX;
		if (v < SMP_MIN)
			return SMP_MIN;
		return v;
	endfunction

	// Gain is (p/1000)^2 in Q1.16, rounded to nearest with ties upward.
	function automatic longint square_gain(input longint p, input longint lim);
		longint a;
		if (p > lim)
			p = lim;
		if (p < -lim)
			p = -lim;
		a = (p < 0) ? -p : p;
		return (a * a * 4096 + 31250) / 62500;
	endfunction

	function automatic void load_settings();
		longint ms;
		longint d;
		ms = longint'(ms_reg);
		if (ms > 4000)
			ms = 4000;
		d = ms * longint'(rate_reg) / 1000;
		if (d < 1)
			d = 1;
		if (d > DEPTH - 2)
			d = DEPTH - 2;
		tap_delay    = int'(d);
		level_gain_q = square_gain(longint'(level_reg), 1000);
		fb_gain_q    = square_gain(longint'(fb_reg), 999);
	endfunction

	// One sample through the echo: read the tap, write back the fed-back sum,
	// and return the dry plus scaled echo. Products are rounded to the sample
	// grid by adding half an LSB and shifting with floor.
	function automatic logic signed [SB-1:0] echo_step(input logic signed [SB-1:0] x,
			input logic be);
		longint tap;
		longint fed;
		longint y;
		int rd;
		if (take_settings)
			load_settings();
		rd  = (wr_ptr + DEPTH - tap_delay) % DEPTH;
		tap = longint'(echo_line[rd]);
		fed = clip(longint'(x) + ((tap * fb_gain_q + 32768) >>> 16));
		y   = clip(longint'(x) + ((tap * level_gain_q + 32768) >>> 16));
		echo_line[wr_ptr] = int'(fed);
		wr_ptr = (wr_ptr + 1) % DEPTH;
		take_settings = be;
		return SB'(y);
	endfunction

	// ------------------------------------------------------------------
	// Monitor. Everything is sampled at the rising edge, where all inputs
	// still hold the values driven at the previous edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor_blk
		echo_result_t want;
		echo_result_t got;
		logic signed [SB-1:0] y;
		if (cfg_we) begin
			case (fed_pkg::fed_reg_t'(cfg_idx))
				fed_pkg::REG_DELAY_MS: begin
					ms_reg = cfg_data[fed_pkg::MS_BITS-1:0];
				end
				fed_pkg::REG_SAMPLE_RATE: begin
					rate_reg = cfg_data[fed_pkg::RATE_BITS-1:0];
				end
				fed_pkg::REG_LEVEL: begin
					level_reg = cfg_data[fed_pkg::PERMILLE_BITS-1:0];
				end
				fed_pkg::REG_FEEDBACK: begin
					fb_reg = cfg_data[fed_pkg::PERMILLE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
		if (in_valid && in_ready) begin
			// The predictor runs on every input transfer so that its line stays
			// in step, even when the row carries a hand-typed result.
			y = echo_step(sample_in, block_end);
			want.smp = row_typed ? row_want : y;
			want.be  = block_end;
			pending_echo.push_back(want);
		end
		if (out_valid && out_ready) begin
			got.smp = sample_out;
			got.be  = block_end_out;
			if (pending_echo.size() == 0) begin
				$display("%0t: output transfer with nothing expected, got %0d / %0b",
					$time, got.smp, got.be);
				n_errors++;
			end else begin
				want = pending_echo.pop_front();
				if (got.smp !== want.smp) begin
					$display("%0t: sample_out mismatch, expected %0d, got %0d",
						$time, want.smp, got.smp);
					n_errors++;
				end
				if (got.be !== want.be) begin
					$display("%0t: block_end_out mismatch, expected %0b, got %0b",
						$time, want.be, got.be);
					n_errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result sink. Before each output transfer it stalls for a random number
	// of cycles, unless a steady stretch is running.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// ------------------------------------------------------------------
	// Sample source and register writes.
	// ------------------------------------------------------------------

	// Offers one sample after a random gap and returns at its transfer edge.
	// With no gap, valid stays high and only the payload moves on.
	task automatic push_sample(input logic signed [SB-1:0] s, input logic be,
			input bit typed, input logic signed [SB-1:0] want);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		block_end <= be;
		row_typed <= typed;
		row_want  <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	// Waits until every expected result has come out, then lets the pipeline
	// and the settings logic go quiet before anything is rewritten.
	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_echo.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Writes all four registers on consecutive edges. Bits above a register's
	// width get random junk, which the block must ignore.
	task automatic apply_settings(input logic [fed_pkg::MS_BITS-1:0] ms,
			input logic [fed_pkg::RATE_BITS-1:0] rate,
			input logic [fed_pkg::PERMILLE_BITS-1:0] lvl,
			input logic [fed_pkg::PERMILLE_BITS-1:0] fb);
		cfg_we   <= 1'b1;
		cfg_idx  <= fed_pkg::REG_DELAY_MS;
		cfg_data <= {(fed_pkg::CFG_BITS - fed_pkg::MS_BITS)'($urandom), ms};
		@(posedge clk);
		cfg_idx  <= fed_pkg::REG_SAMPLE_RATE;
		cfg_data <= rate;
		@(posedge clk);
		cfg_idx  <= fed_pkg::REG_LEVEL;
		cfg_data <= {(fed_pkg::CFG_BITS - fed_pkg::PERMILLE_BITS)'($urandom), lvl};
		@(posedge clk);
		cfg_idx  <= fed_pkg::REG_FEEDBACK;
		cfg_data <= {(fed_pkg::CFG_BITS - fed_pkg::PERMILLE_BITS)'($urandom), fb};
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Directed table. A row is either one sample or a full set of register
	// values that is written once the block has gone idle.
	// ------------------------------------------------------------------
	typedef enum {ROW_SAMPLE, ROW_SETTINGS} row_kind_t;

	typedef struct {
		row_kind_t                         kind;
		logic signed [SB-1:0]              smp;
		logic                              be;
		bit                                typed;
		logic signed [SB-1:0]              want;
		logic [fed_pkg::MS_BITS-1:0]       ms;
		logic [fed_pkg::RATE_BITS-1:0]     rate;
		logic [fed_pkg::PERMILLE_BITS-1:0] lvl;
		logic [fed_pkg::PERMILLE_BITS-1:0] fb;
	} stim_row_t;

	function automatic stim_row_t sample_row(input int s, input bit be);
		stim_row_t r;
		r = '{kind: ROW_SAMPLE, default: '0};
		r.smp = SB'(s);
		r.be  = be;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input int s, input bit be, input int want);
		stim_row_t r;
		r = sample_row(s, be);
		r.typed = 1'b1;
		r.want  = SB'(want);
		return r;
	endfunction

	function automatic stim_row_t settings_row(input int ms, input int rate, input int lvl,
			input int fb);
		stim_row_t r;
		r = '{kind: ROW_SETTINGS, default: '0};
		r.ms   = fed_pkg::MS_BITS'(ms);
		r.rate = fed_pkg::RATE_BITS'(rate);
		r.lvl  = fed_pkg::PERMILLE_BITS'(lvl);
		r.fb   = fed_pkg::PERMILLE_BITS'(fb);
		return r;
	endfunction

	stim_row_t stim_table [$];

	initial begin : stimulus
		logic signed [SB-1:0]              smp;
		logic [fed_pkg::MS_BITS-1:0]       ms;
		logic [fed_pkg::RATE_BITS-1:0]     rate;
		logic [fed_pkg::PERMILLE_BITS-1:0] lvl;
		logic [fed_pkg::PERMILLE_BITS-1:0] fb;
		int                                n_items;

		stim_table = {
			// Reset settings give a tap far behind an all-zero line, so the
			// dry sample comes straight through.
			typed_row(8388607, 1'b0, 8388607),
			typed_row(-8388608, 1'b0, -8388608),
			typed_row(0, 1'b0, 0),
			typed_row(-1, 1'b1, -1),
			// Zero milliseconds gives a one-sample tap; full level and feedback
			// drive both sums into saturation.
			settings_row(0, 48000, 1000, 999),
			sample_row(8388607, 1'b0),
			sample_row(8388607, 1'b0),
			sample_row(-8388608, 1'b0),
			sample_row(-8388608, 1'b1),
			// Delay above 4000 ms at the top rate clamps to the deepest tap,
			// and the delay change leaves the line in place.
			settings_row(4095, 262143, -1000, -999),
			sample_row(100, 1'b0),
			sample_row(-100, 1'b1),
			// Permille codes past the range clamp to full level and feedback.
			settings_row(1, 8000, 1023, -1024),
			sample_row(4194304, 1'b0),
			sample_row(-4194304, 1'b0),
			sample_row(8388607, 1'b1),
			sample_row(1234567, 1'b0),
			// Written in the middle of a block: the old settings hold until the
			// sample after the next block end. A zero rate gives a one-sample
			// tap, and zero gains pass the dry sample.
			settings_row(2, 0, 0, 0),
			sample_row(-7654321, 1'b0),
			sample_row(8388607, 1'b1),
			typed_row(555, 1'b0, 555),
			typed_row(-8388608, 1'b1, -8388608),
			// A small rate and middle gains.
			settings_row(3, 1000, 707, 500),
			sample_row(3000000, 1'b0),
			sample_row(-2000000, 1'b0),
			sample_row(0, 1'b0),
			sample_row(700000, 1'b1)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_SETTINGS) begin
				settle_idle();
				apply_settings(stim_table[i].ms, stim_table[i].rate,
					stim_table[i].lvl, stim_table[i].fb);
			end else begin
				push_sample(stim_table[i].smp, stim_table[i].be,
					stim_table[i].typed, stim_table[i].want);
			end
		end

		// Random phases. Most use taps of a few to a few dozen samples so the
		// feedback keeps circulating within a phase; a few reach much deeper.
		for (int ph = 0; ph < 14; ph++) begin
			settle_idle();
			case ($urandom_range(0, 9))
				7, 8: ms = fed_pkg::MS_BITS'($urandom_range(0, 40));
				9: ms = fed_pkg::MS_BITS'($urandom_range(0, 4095));
				default: ms = fed_pkg::MS_BITS'($urandom_range(0, 2));
			endcase
			if ($urandom_range(0, 3) == 0)
				rate = fed_pkg::RATE_BITS'($urandom_range(0, 262143));
			else
				rate = fed_pkg::RATE_BITS'($urandom_range(8000, 64000));
			if ($urandom_range(0, 4) == 0)
				lvl = fed_pkg::PERMILLE_BITS'($urandom);
			else
				lvl = fed_pkg::PERMILLE_BITS'(int'($urandom_range(0, 2000)) - 1000);
			if ($urandom_range(0, 4) == 0)
				fb = fed_pkg::PERMILLE_BITS'($urandom);
			else
				fb = fed_pkg::PERMILLE_BITS'(int'($urandom_range(0, 2000)) - 1000);
			apply_settings(ms, rate, lvl, fb);

			steady  = ($urandom_range(0, 3) == 0);
			n_items = $urandom_range(70, 120);
			for (int k = 0; k < n_items; k++) begin
				// Loud samples are frequent so that saturation is hit often.
				case ($urandom_range(0, 7))
					0: smp = SB'(SMP_MAX);
					1: smp = SB'(SMP_MIN);
					2: smp = SB'(int'($urandom_range(0, 511)) - 256);
					default: smp = SB'($urandom);
				endcase
				push_sample(smp, ($urandom_range(0, 15) == 0), 1'b0, '0);
			end
			steady = 1'b0;
		end

		settle_idle();
		if (pending_echo.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_echo.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
